// ===== design/i2a_pkg.sv =====
// Shared types, constants and helpers for the integer to ASCII converter.
package i2a_pkg;

   // Default width of the converted value
   localparam int VALUE_WIDTH_DEF = 64;

   // Mode codes
   localparam logic [1:0] FUNC_UDEC = 2'd0;
   localparam logic [1:0] FUNC_SDEC = 2'd1;
   localparam logic [1:0] FUNC_HEX  = 2'd2;

   // Fixed characters
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SUFFIX = 8'h68;

   localparam logic [7:0] HEX_GLYPHS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_STRIP,
      ST_SIGN,
      ST_DIGIT,
      ST_SUFFIX
   } state_type;

   // Commands from the sequencer to the digit unit
   typedef struct packed {
      logic load;
      logic hex;
      logic step;
      logic shift;
   } dab_ctrl_type;

   // Decimal digits needed for a w-bit unsigned value: floor(w*log10(2)) + 1
   function automatic int digit_count(input int w);
      digit_count = (w * 30103) / 100000 + 1;
   endfunction

   // ASCII glyph of one digit
   function automatic logic [7:0] glyph(input logic [3:0] d);
      glyph = HEX_GLYPHS[d];
   endfunction

endpackage

// ===== design/i2a_if.sv =====
// Request and response channel interfaces of the integer to ASCII converter.
interface i2a_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [1:0]  func;

   modport source (output valid, output value, output func, input ready);
   modport sink   (input valid, input value, input func, output ready);
endinterface

interface i2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ascii_char;
   logic       last;

   modport source (output valid, output ascii_char, output last, input ready);
   modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// ===== design/i2a_dabble.sv =====
// Digit register with the shared shift-and-add-3 unit of the converter.
module i2a_dabble #(
   parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  i2a_pkg::dab_ctrl_type  ctrl,
   input  logic [VALUE_WIDTH-1:0] mag,
   output logic [3:0]             top_digit
);

   localparam int DIGITS = i2a_pkg::digit_count(VALUE_WIDTH);
   localparam int BCD_W  = DIGITS * 4;

   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       adj;

   // Add 3 to every digit of five or more
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // Load, step the conversion or drop the top digit
   always_comb begin
      bcd_in = bcd_ff;
      mag_in = mag_ff;
      if (ctrl.load) begin
         mag_in = mag;
         if (ctrl.hex) begin
            bcd_in = BCD_W'(mag);
         end else begin
            bcd_in = '0;
         end
      end else if (ctrl.step) begin
         bcd_in = {adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
      end else if (ctrl.shift) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      mag_ff <= mag_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

// ===== design/integer_to_ascii_converter.sv =====
// Top level of the integer to ASCII converter: sequencer and response register.
// Decimal: a shift-and-add-3 step per value bit, then a strip step per leading zero digit
// plus a final one, a sign step when negative and a step per character. A new request is
// accepted only in idle, after the last character of the previous one is loaded.
// Hex: no conversion, the same strip and character steps plus the suffix. Response stalls
// hold the character steps; synchronous reset returns to idle and empties the output.
module integer_to_ascii_converter #(
   parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   i2a_req_if.sink   req_ch,
   i2a_rsp_if.source rsp_ch
);

   localparam int DIGITS  = i2a_pkg::digit_count(VALUE_WIDTH);
   localparam int CNT_W   = $clog2(DIGITS + 1);
   localparam int BIT_W   = $clog2(VALUE_WIDTH);

   i2a_pkg::state_type    state_ff, state_in;
   i2a_pkg::dab_ctrl_type ctrl;

   logic [BIT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]       dig_cnt_ff, dig_cnt_in;
   logic                   neg_ff, neg_in;
   logic                   hex_ff, hex_in;
   logic [VALUE_WIDTH-1:0] v, mag;
   logic                   req_neg;
   logic [3:0]             top_digit;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       out_load;
   logic       out_free;

   // Magnitude of the incoming request
   assign v       = req_ch.value[VALUE_WIDTH-1:0];
   assign req_neg = (req_ch.func == i2a_pkg::FUNC_SDEC) && v[VALUE_WIDTH-1];
   assign mag     = req_neg ? VALUE_WIDTH'(~v + 1'b1) : v;

   assign req_ch.ready = (state_ff == i2a_pkg::ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   i2a_dabble #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dabble (
      .clock    (clock),
      .ctrl     (ctrl),
      .mag      (mag),
      .top_digit(top_digit)
   );

   // Sequencer: next state, digit unit commands and character selection
   always_comb begin
      state_in    = state_ff;
      bit_cnt_in  = bit_cnt_ff;
      dig_cnt_in  = dig_cnt_ff;
      neg_in      = neg_ff;
      hex_in      = hex_ff;
      ctrl        = '0;
      out_load    = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         i2a_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               neg_in = req_neg;
               hex_in = (req_ch.func == i2a_pkg::FUNC_HEX);
               ctrl.hex = hex_in;
               if (req_ch.func == i2a_pkg::FUNC_HEX) begin
                  // count every nibble of the digit register, padding included
                  ctrl.load  = 1'b1;
                  dig_cnt_in = CNT_W'(DIGITS);
                  state_in   = i2a_pkg::ST_STRIP;
               end else if (req_ch.func == i2a_pkg::FUNC_UDEC ||
                            req_ch.func == i2a_pkg::FUNC_SDEC) begin
                  ctrl.load  = 1'b1;
                  dig_cnt_in = CNT_W'(DIGITS);
                  bit_cnt_in = BIT_W'(VALUE_WIDTH - 1);
                  state_in   = i2a_pkg::ST_CONVERT;
               end
            end
         end
         i2a_pkg::ST_CONVERT: begin
            ctrl.step = 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = i2a_pkg::ST_STRIP;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         i2a_pkg::ST_STRIP: begin
            if (top_digit == 4'd0 && dig_cnt_ff > CNT_W'(1)) begin
               ctrl.shift = 1'b1;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = i2a_pkg::ST_SIGN;
            end else begin
               state_in = i2a_pkg::ST_DIGIT;
            end
         end
         i2a_pkg::ST_SIGN: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = i2a_pkg::CHAR_MINUS;
               rsp_last_in = 1'b0;
               state_in    = i2a_pkg::ST_DIGIT;
            end
         end
         i2a_pkg::ST_DIGIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = i2a_pkg::glyph(top_digit);
               rsp_last_in = (dig_cnt_ff == CNT_W'(1)) && !hex_ff;
               ctrl.shift  = 1'b1;
               dig_cnt_in  = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == CNT_W'(1)) begin
                  state_in = hex_ff ? i2a_pkg::ST_SUFFIX : i2a_pkg::ST_IDLE;
               end
            end
         end
         i2a_pkg::ST_SUFFIX: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = i2a_pkg::CHAR_SUFFIX;
               rsp_last_in = 1'b1;
               state_in    = i2a_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = i2a_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the response until it is taken
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2a_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      neg_ff      <= neg_in;
      hex_ff      <= hex_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.ascii_char = rsp_char_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // Decimal digits leaving the digit unit are proper decimal digits
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == i2a_pkg::ST_DIGIT && !hex_ff) |-> (top_digit < 4'd10))
      else $error("digit unit produced a non-decimal digit");

   // Never send a digit with an exhausted count
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == i2a_pkg::ST_DIGIT) |-> (dig_cnt_ff != '0))
      else $error("digit sent with zero count");

   // The conversion runs its full number of steps
   a_convert_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == i2a_pkg::ST_STRIP && $past(state_ff) == i2a_pkg::ST_CONVERT)
      |-> ($past(bit_cnt_ff) == '0))
      else $error("conversion left early");

   // A new character only replaces a taken or empty response
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(rsp_char_ff))
      else $error("pending response overwritten");

endmodule
